// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with a synchronous reset that disables them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// File: hdl/dttf_pkg.sv
// ----------------------------------------------------------------------------
// dttf_pkg
// Shared types, character codes and constants of the decimal text parser.
// ----------------------------------------------------------------------------
package dttf_pkg;

   localparam int VALUE_BITS               = 64;
   localparam int DEF_FRACTION_BITS        = 32;
   localparam int DEF_FRACTION_DIGITS_KEPT = 10;
   localparam int MAX_DIGITS_KEPT          = 15;

   localparam logic [4:0] EXP_MAX = 5'd31;

   localparam logic [VALUE_BITS-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_BITS-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_BITS-1:0] POS_LIMIT_DIV10 = POS_LIMIT / 64'd10;
   localparam logic [VALUE_BITS-1:0] NEG_LIMIT_DIV10 = NEG_LIMIT / 64'd10;

   // ASCII codes
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_LOW_E = 8'h65;
   localparam logic [7:0] CHAR_UP_E  = 8'h45;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   // Queue between classifier and parser
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_FILL_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CLS_BLANK,
      CLS_MINUS,
      CLS_PLUS,
      CLS_DIGIT,
      CLS_POINT,
      CLS_EXP,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      logic           last;
   } item_type;

   typedef struct packed {
      logic                       valid;
      logic [QUEUE_FILL_BITS-1:0] fill;
   } queue_status_type;

   typedef enum logic [2:0] {
      PH_BLANKS = 3'd0,
      PH_INT    = 3'd1,
      PH_FRAC   = 3'd2,
      PH_EXP    = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_FETCH,
      ST_APPLY,
      ST_SCALE,
      ST_EMIT
   } back_state_type;

   typedef logic [VALUE_BITS-1:0] weight_table_type [0:MAX_DIGITS_KEPT];

   // floor(2^frac_bits / 10^k), evaluated at elaboration
   function automatic weight_table_type frac_weight_table(input int frac_bits);
      weight_table_type w;
      w[0] = 64'd1 << frac_bits;
      for (int k = 1; k <= MAX_DIGITS_KEPT; k++) begin
         w[k] = w[k-1] / 64'd10;
      end
      return w;
   endfunction

endpackage

// File: hdl/dttf_front.sv
// ----------------------------------------------------------------------------
// dttf_front
// Classifies incoming text bytes and queues them for the parser.
// ----------------------------------------------------------------------------
module dttf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_character,
   input  logic                       req_last_of_string,
   input  logic                       q_pop,
   output dttf_pkg::item_type         q_item,
   output dttf_pkg::queue_status_type q_status
);
   import dttf_pkg::*;

   item_type                   queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_FILL_BITS-1:0] fill_ff, fill_in;
   logic                       push;
   item_type                   new_item;
   logic [7:0]                 digit_off;

   // classify
   always_comb begin
      digit_off      = req_character - CHAR_ZERO;
      new_item.digit = digit_off[3:0];
      new_item.last  = req_last_of_string;
      if (req_character inside {CHAR_SPACE, CHAR_TAB}) begin
         new_item.cls = CLS_BLANK;
      end else if (req_character == CHAR_MINUS) begin
         new_item.cls = CLS_MINUS;
      end else if (req_character == CHAR_PLUS) begin
         new_item.cls = CLS_PLUS;
      end else if (req_character inside {[CHAR_ZERO:CHAR_NINE]}) begin
         new_item.cls = CLS_DIGIT;
      end else if (req_character == CHAR_POINT) begin
         new_item.cls = CLS_POINT;
      end else if (req_character inside {CHAR_LOW_E, CHAR_UP_E}) begin
         new_item.cls = CLS_EXP;
      end else begin
         new_item.cls = CLS_OTHER;
      end
   end

   assign req_stall = (fill_ff == QUEUE_FILL_BITS'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign q_item         = queue_ff[rd_ptr_ff];
   assign q_status.valid = (fill_ff != '0);
   assign q_status.fill  = fill_ff;

endmodule

// File: hdl/dttf_back.sv
// ----------------------------------------------------------------------------
// dttf_back
// Parser: phase tracking, saturating accumulate, exponent scaling, result.
// ----------------------------------------------------------------------------
module dttf_back #(
   parameter int FRACTION_BITS        = dttf_pkg::DEF_FRACTION_BITS,
   parameter int FRACTION_DIGITS_KEPT = dttf_pkg::DEF_FRACTION_DIGITS_KEPT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dttf_pkg::item_type         q_item,
   input  dttf_pkg::queue_status_type q_status,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [63:0]         rsp_value,
   output logic                       rsp_saturated
);
   import dttf_pkg::*;

   localparam weight_table_type FRAC_WEIGHT = frac_weight_table(FRACTION_BITS);
   localparam logic [3:0]       KEPT        = 4'(FRACTION_DIGITS_KEPT);

   back_state_type         state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic                   negative_ff, negative_in;
   logic [VALUE_BITS-1:0]  mag_ff, mag_in;
   logic [3:0]             fpos_ff, fpos_in;
   logic [4:0]             exp_ff, exp_in;
   logic                   ovf_ff, ovf_in;
   logic [VALUE_BITS-1:0]  op_ff, op_in;
   logic                   last_ff, last_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic                   rsp_sat_ff, rsp_sat_in;

   logic [VALUE_BITS-1:0]  lim, lim_div10, ten_val, weight, frac_prod;
   logic [VALUE_BITS:0]    sum;
   logic                   ten_over, add_over;
   logic                   consumed, go_apply, out_free;
   phase_type              phase_eff;
   logic [3:0]             fpos_next;
   logic [8:0]             exp_ext, exp_acc;

   // shared arithmetic
   always_comb begin
      lim       = negative_ff ? NEG_LIMIT : POS_LIMIT;
      lim_div10 = negative_ff ? NEG_LIMIT_DIV10 : POS_LIMIT_DIV10;
      ten_over  = (mag_ff > lim_div10);
      ten_val   = (mag_ff << 3) + (mag_ff << 1);
      sum       = {1'b0, mag_ff} + {1'b0, op_ff};
      add_over  = (sum > {1'b0, lim});
      fpos_next = fpos_ff + 4'd1;
      weight    = FRAC_WEIGHT[fpos_next];
      frac_prod = (q_item.digit[0] ? weight        : '0) +
                  (q_item.digit[1] ? (weight << 1) : '0) +
                  (q_item.digit[2] ? (weight << 2) : '0) +
                  (q_item.digit[3] ? (weight << 3) : '0);
      exp_ext   = {4'd0, exp_ff};
      exp_acc   = (exp_ext << 3) + (exp_ext << 1) + {5'd0, q_item.digit};
      out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // byte decode
   always_comb begin
      consumed  = 1'b0;
      phase_eff = phase_ff;
      if (phase_ff == PH_BLANKS) begin
         case (q_item.cls)
            CLS_BLANK, CLS_MINUS, CLS_PLUS: consumed = 1'b1;
            default:                        phase_eff = PH_INT;
         endcase
      end
      go_apply = !consumed && (q_item.cls == CLS_DIGIT) &&
                 ((phase_eff == PH_INT) ||
                  ((phase_eff == PH_FRAC) && (fpos_ff < KEPT)));
   end

   assign q_pop = (state_ff == ST_FETCH) && q_status.valid;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FETCH: begin
            if (q_status.valid) begin
               if (go_apply) begin
                  state_in = ST_APPLY;
               end else if (q_item.last) begin
                  state_in = ST_SCALE;
               end
            end
         end
         ST_APPLY: state_in = last_ff ? ST_SCALE : ST_FETCH;
         ST_SCALE: state_in = (cnt_ff == '0) ? ST_EMIT : ST_SCALE;
         ST_EMIT:  state_in = out_free ? ST_FETCH : ST_EMIT;
         default:  state_in = ST_FETCH;
      endcase
   end

   // datapath
   always_comb begin
      phase_in     = phase_ff;
      negative_in  = negative_ff;
      mag_in       = mag_ff;
      fpos_in      = fpos_ff;
      exp_in       = exp_ff;
      ovf_in       = ovf_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      case (state_ff)
         ST_FETCH: begin
            if (q_status.valid) begin
               last_in = q_item.last;
               if (phase_ff == PH_BLANKS) begin
                  case (q_item.cls)
                     CLS_MINUS: begin
                        negative_in = 1'b1;
                        phase_in    = PH_INT;
                     end
                     CLS_PLUS: phase_in = PH_INT;
                     default:  phase_in = phase_ff;
                  endcase
               end
               if (!consumed) begin
                  phase_in = phase_eff;
                  case (phase_eff)
                     PH_INT: begin
                        case (q_item.cls)
                           CLS_DIGIT: begin
                              if (!ovf_ff) begin
                                 if (ten_over) begin
                                    mag_in = lim;
                                    ovf_in = 1'b1;
                                 end else begin
                                    mag_in = ten_val;
                                 end
                              end
                              op_in = VALUE_BITS'(q_item.digit) << FRACTION_BITS;
                           end
                           CLS_POINT: phase_in = PH_FRAC;
                           CLS_EXP:   phase_in = PH_EXP;
                           default:   phase_in = PH_DONE;
                        endcase
                     end
                     PH_FRAC: begin
                        case (q_item.cls)
                           CLS_DIGIT: begin
                              if (fpos_ff < KEPT) begin
                                 fpos_in = fpos_next;
                                 op_in   = frac_prod;
                              end
                           end
                           CLS_EXP: phase_in = PH_EXP;
                           default: phase_in = PH_DONE;
                        endcase
                     end
                     PH_EXP: begin
                        if (q_item.cls == CLS_DIGIT) begin
                           exp_in = (exp_acc > {4'd0, EXP_MAX}) ? EXP_MAX : exp_acc[4:0];
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                     default: phase_in = PH_DONE;
                  endcase
               end
               cnt_in = exp_in;
            end
         end
         ST_APPLY: begin
            if (!ovf_ff) begin
               if (add_over) begin
                  mag_in = lim;
                  ovf_in = 1'b1;
               end else begin
                  mag_in = sum[VALUE_BITS-1:0];
               end
            end
         end
         ST_SCALE: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 5'd1;
               if (!ovf_ff) begin
                  if (ten_over) begin
                     mag_in = lim;
                     ovf_in = 1'b1;
                  end else begin
                     mag_in = ten_val;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = negative_ff ? ('0 - mag_ff) : mag_ff;
               rsp_sat_in   = ovf_ff;
               phase_in     = PH_BLANKS;
               negative_in  = 1'b0;
               mag_in       = '0;
               fpos_in      = '0;
               exp_in       = '0;
               ovf_in       = 1'b0;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         phase_ff     <= PH_BLANKS;
         negative_ff  <= 1'b0;
         mag_ff       <= '0;
         fpos_ff      <= '0;
         exp_ff       <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         negative_ff  <= negative_in;
         mag_ff       <= mag_in;
         fpos_ff      <= fpos_in;
         exp_ff       <= exp_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = signed'(rsp_value_ff);
   assign rsp_saturated = rsp_sat_ff;

endmodule

// File: hdl/decimal_text_to_fixed_point_core.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_core
// Parses decimal text, one byte per beat, into signed Q31.32 fixed point.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   req     | in        | req_valid/req_stall  | req_character, req_last_of_string
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_value, rsp_saturated
//
// Steps: an integer digit or a kept fraction digit passes ST_FETCH (times ten or
//   weight product), then ST_APPLY (the saturating 64-bit add); any other beat,
//   exponent digits and dropped fraction digits included, needs only ST_FETCH. A
//   beat marked last then runs ST_SCALE, exponent (at most 31) steps of the single
//   times-ten unit, and ST_EMIT, which loads the output register.
// Reset: synchronous, active high; clears the queue, parser state and rsp_valid.
// Stalls: req_stall rises when the 2-entry queue is full. rsp_stall holds the
//   output register; the parser keeps consuming beats until it has its next
//   result ready.
//
`include "assert_macros.svh"

module decimal_text_to_fixed_point_core #(
   parameter int FRACTION_BITS        = dttf_pkg::DEF_FRACTION_BITS,
   parameter int FRACTION_DIGITS_KEPT = dttf_pkg::DEF_FRACTION_DIGITS_KEPT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_character,
   input  logic               req_last_of_string,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_value,
   output logic               rsp_saturated
);
   import dttf_pkg::*;

   item_type         q_item;
   queue_status_type q_status;
   logic             q_pop;
   logic             sat_at_limit;

   // front: classify and queue each byte
   dttf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_character      (req_character),
      .req_last_of_string (req_last_of_string),
      .q_pop              (q_pop),
      .q_item             (q_item),
      .q_status           (q_status)
   );

   // back: accumulate, scale by exponent, drive the result register
   dttf_back #(
      .FRACTION_BITS        (FRACTION_BITS),
      .FRACTION_DIGITS_KEPT (FRACTION_DIGITS_KEPT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_item        (q_item),
      .q_status      (q_status),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_saturated (rsp_saturated)
   );

   assign sat_at_limit = ($unsigned(rsp_value) == POS_LIMIT) ||
                         ($unsigned(rsp_value) == NEG_LIMIT);

   // queue occupancy never passes its depth
   `ASSERT_NEVER(a_fill_bound, clock, reset, q_status.fill > QUEUE_FILL_BITS'(QUEUE_DEPTH), "queue overfilled")

   // parser only takes an entry that is there
   `ASSERT_CLK(a_pop_has_item, clock, reset, q_pop |-> q_status.valid, "pop from empty queue")

   // a clamped result is exactly one of the two limits
   `ASSERT_CLK(a_sat_is_limit, clock, reset, (rsp_valid && rsp_saturated) |-> sat_at_limit, "saturated value is not a limit")

endmodule

// File: bench/decimal_text_to_fixed_point_core_tb.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_core_tb
// Streams decimal text into the parser one byte per beat and checks each
// Q31.32 result against a cycle-free parser model kept in the bench.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import dttf_pkg::*;

   localparam int FRAC_BITS      = 32;
   localparam int DIGITS_KEPT    = 10;
   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 60;    // worst case: 31 scaling steps plus pipeline
   localparam int LONG_HOLD      = 300;   // receiver hold-off used to fill the block
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat on either channel
   localparam int REPORT_LIMIT   = 10;

   localparam logic [63:0] UNIT = 64'd1 << FRAC_BITS;

   typedef struct packed {
      logic [63:0] value;
      logic        saturated;
   } fixed_number_type;

   // Bytes that steer the parser; mixed with arbitrary bytes for noise.
   localparam logic [7:0] SYNTAX_POOL [0:9] = '{
      CHAR_MINUS, CHAR_PLUS, CHAR_POINT, CHAR_LOW_E, CHAR_UP_E,
      CHAR_SPACE, CHAR_TAB, CHAR_ZERO, CHAR_NINE, 8'h35
   };

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic               req_stall;
   logic [7:0]         req_character      = 8'h00;
   logic               req_last_of_string = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall          = 1'b0;
   logic signed [63:0] rsp_value;
   logic               rsp_saturated;

   // Bench-side parser state, updated on every accepted req beat.
   phase_type   prs_phase;
   bit          prs_negative;
   logic [63:0] prs_magnitude;
   int unsigned prs_frac_digits;
   int unsigned prs_exponent;
   bit          prs_clamped;

   fixed_number_type expected_numbers[$];
   logic [7:0]       text_buffer[$];

   int  mismatch_count        = 0;
   int  quiet_cycles          = 0;
   int  hold_left             = 0;
   bit  idle_enabled          = 1'b1;
   bit  pressure_hold_request = 1'b0;

   decimal_text_to_fixed_point_core #(
      .FRACTION_BITS        (FRAC_BITS),
      .FRACTION_DIGITS_KEPT (DIGITS_KEPT)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_character      (req_character),
      .req_last_of_string (req_last_of_string),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value          (rsp_value),
      .rsp_saturated      (rsp_saturated)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------
   function automatic logic [63:0] magnitude_limit();
      return prs_negative ? NEG_LIMIT : POS_LIMIT;
   endfunction

   // Once clamped, the magnitude is frozen for the rest of the string.
   function automatic void add_to_magnitude(input logic [63:0] x);
      logic [63:0] lim;
      lim = magnitude_limit();
      if (prs_clamped) return;
      if (prs_magnitude > lim || x > lim - prs_magnitude) begin
         prs_magnitude = lim;
         prs_clamped   = 1'b1;
      end else begin
         prs_magnitude = prs_magnitude + x;
      end
   endfunction

   function automatic void scale_magnitude_by_ten();
      if (prs_clamped) return;
      if (prs_magnitude > magnitude_limit() / 64'd10) begin
         prs_magnitude = magnitude_limit();
         prs_clamped   = 1'b1;
      end else begin
         prs_magnitude = prs_magnitude * 64'd10;
      end
   endfunction

   // Truncated weight of the k-th fraction digit: floor(2^FRAC_BITS / 10^k).
   function automatic logic [63:0] fraction_weight(input int unsigned k);
      logic [63:0] p;
      p = 64'd1;
      for (int unsigned i = 0; i < k; i++) p = p * 64'd10;
      return UNIT / p;
   endfunction

   function automatic void clear_parse_state();
      prs_phase       = PH_BLANKS;
      prs_negative    = 1'b0;
      prs_magnitude   = '0;
      prs_frac_digits = 0;
      prs_exponent    = 0;
      prs_clamped     = 1'b0;
   endfunction

   function automatic void parse_text_byte(input logic [7:0] ch, input logic last);
      bit               consumed;
      bit               is_digit;
      bit               is_exp_letter;
      logic [63:0]      d;
      int unsigned      n;
      fixed_number_type result;
      consumed      = 1'b0;
      is_digit      = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      is_exp_letter = (ch == CHAR_LOW_E) || (ch == CHAR_UP_E);
      d             = 64'(ch - CHAR_ZERO);

      // Leading blanks and the optional sign are eaten here; any other
      // byte falls through into the integer phase.
      if (prs_phase == PH_BLANKS) begin
         consumed = 1'b1;
         if (ch == CHAR_SPACE || ch == CHAR_TAB) begin
         end else if (ch == CHAR_MINUS) begin
            prs_negative = 1'b1;
            prs_phase    = PH_INT;
         end else if (ch == CHAR_PLUS) begin
            prs_phase = PH_INT;
         end else begin
            prs_phase = PH_INT;
            consumed  = 1'b0;
         end
      end

      if (!consumed) begin
         case (prs_phase)
            PH_INT: begin
               if (is_digit) begin
                  scale_magnitude_by_ten();
                  add_to_magnitude(d * UNIT);
               end else if (ch == CHAR_POINT) begin
                  prs_phase = PH_FRAC;
               end else if (is_exp_letter) begin
                  prs_phase = PH_EXP;
               end else begin
                  prs_phase = PH_DONE;
               end
            end
            PH_FRAC: begin
               if (is_digit) begin
                  if (prs_frac_digits < DIGITS_KEPT) begin
                     prs_frac_digits++;
                     add_to_magnitude(d * fraction_weight(prs_frac_digits));
                  end
               end else if (is_exp_letter) begin
                  prs_phase = PH_EXP;
               end else begin
                  prs_phase = PH_DONE;
               end
            end
            PH_EXP: begin
               if (is_digit) begin
                  n            = prs_exponent * 10 + int'(d);
                  prs_exponent = (n > int'(EXP_MAX)) ? int'(EXP_MAX) : n;
               end else begin
                  prs_phase = PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end

      if (last) begin
         for (int unsigned i = 0; i < prs_exponent; i++) scale_magnitude_by_ten();
         result.value     = prs_negative ? (64'd0 - prs_magnitude) : prs_magnitude;
         result.saturated = prs_clamped;
         expected_numbers.push_back(result);
         clear_parse_state();
      end
   endfunction

   // ------------------------------------------------------------------
   // Receiver: short random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (pressure_hold_request) begin
         pressure_hold_request = 1'b0;
         rsp_stall <= 1'b1;
         hold_left = LONG_HOLD - 1;
      end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         hold_left = $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Result check: every rsp beat against the oldest expected number
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      fixed_number_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_numbers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected result value=%h saturated=%b",
                        $realtime, rsp_value, rsp_saturated);
         end else begin
            want = expected_numbers.pop_front();
            if (rsp_value !== want.value || rsp_saturated !== want.saturated) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result mismatch: expected value=%h saturated=%b, got value=%h saturated=%b",
                           $realtime, want.value, want.saturated, rsp_value, rsp_saturated);
            end
         end
      end
   end

   // Watchdog: ends the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   // One req beat; returns at the edge where it was taken.
   task automatic send_beat(input logic [7:0] ch, input logic last);
      if (idle_enabled && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_character      <= ch;
      req_last_of_string <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_text_byte(ch, last);
   endtask

   // Sends text_buffer as one string, last flag on its final byte.
   task automatic send_text_buffer(inout int beats);
      int count;
      count = text_buffer.size();
      for (int i = 0; i < count; i++) send_beat(text_buffer[i], i == count - 1);
      beats += count;
      text_buffer.delete();
   endtask

   task automatic send_string(input string s);
      int beats;
      beats = 0;
      for (int i = 0; i < s.len(); i++) text_buffer.push_back(s[i]);
      send_text_buffer(beats);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (expected_numbers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_digits(input int count);
      for (int i = 0; i < count; i++)
         text_buffer.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   // Well-formed number with random content, sometimes with trailing junk.
   task automatic build_number_text();
      int    pick;
      string edge_int;
      repeat ($urandom_range(0, 2))
         text_buffer.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      pick = $urandom_range(0, 2);
      if (pick == 1) text_buffer.push_back(CHAR_MINUS);
      if (pick == 2) text_buffer.push_back(CHAR_PLUS);

      pick = $urandom_range(0, 9);
      if (pick == 0) begin
      end else if (pick <= 6) begin
         push_digits($urandom_range(1, 3));
      end else if (pick <= 8) begin
         push_digits($urandom_range(4, 11));
      end else begin
         // values right at the signed range boundary
         case ($urandom_range(0, 2))
            0: edge_int = "2147483647";
            1: edge_int = "2147483648";
            default: edge_int = "9999999999";
         endcase
         for (int i = 0; i < edge_int.len(); i++) text_buffer.push_back(edge_int[i]);
      end

      if ($urandom_range(0, 1)) begin
         text_buffer.push_back(CHAR_POINT);
         if ($urandom_range(0, 9) < 3) push_digits($urandom_range(8, 13));
         else                          push_digits($urandom_range(0, 4));
      end

      if ($urandom_range(0, 3) == 0) begin
         text_buffer.push_back($urandom_range(0, 1) ? CHAR_LOW_E : CHAR_UP_E);
         pick = $urandom_range(0, 9);
         if (pick < 7)      push_digits(1);
         else if (pick < 9) push_digits(2);
         else               push_digits($urandom_range(3, 4));
      end

      if ($urandom_range(0, 9) < 3)
         repeat ($urandom_range(1, 2)) text_buffer.push_back(8'($urandom_range(0, 255)));

      if (text_buffer.size() == 0) text_buffer.push_back(8'($urandom_range(0, 255)));
   endtask

   // Short noise string: syntax bytes and arbitrary bytes in random order.
   task automatic build_noise_text();
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 1)) text_buffer.push_back(SYNTAX_POOL[$urandom_range(0, 9)]);
         else                      text_buffer.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_random_strings(input int beat_target);
      int beats;
      beats = 0;
      while (beats < beat_target) begin
         if ($urandom_range(0, 9) < 8) build_number_text();
         else                          build_noise_text();
         send_text_buffer(beats);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed_cases();
      int beats;
      beats = 0;
      send_string("\t-");     // sign alone: no digits, value zero
      send_string("+1e+2");   // sign after the exponent letter ends the number
      send_string("1.5.5");   // second point ends the number
      send_string("9E99");    // exponent count clamps, nonzero value saturates
      send_string("0e99");    // zero stays zero under a huge exponent
      // bytes after the end are ignored; also the byte extremes
      text_buffer.push_back(8'h37);
      text_buffer.push_back(8'hFF);
      text_buffer.push_back(8'h00);
      send_text_buffer(beats);
   endtask

   task automatic test_random_text(input int beat_target);
      send_random_strings(beat_target);
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering
   // beats, so the internal queue fills and req_stall has to rise.
   task automatic test_output_backpressure();
      idle_enabled          = 1'b0;
      pressure_hold_request = 1'b1;
      send_random_strings(60);
      idle_enabled = 1'b1;
   endtask

   // Sender pauses until everything outstanding has been returned.
   task automatic test_sender_pause();
      wait_all_results();
      send_random_strings(40);
   endtask

   task automatic test_streaming_no_idle();
      idle_enabled = 1'b0;
      send_random_strings(150);
   endtask

   initial begin
      clear_parse_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      wait_all_results();
      test_random_text(450);
      test_output_backpressure();
      test_sender_pause();
      test_streaming_no_idle();
      wait_all_results();

      if (mismatch_count == 0 && expected_numbers.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
